>>> design/nfps_pkg.sv
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared widths, register indexes and defaults for the nearest four point
// select block.
// ----------------------------------------------------------------------------
`default_nettype none

package nfps_pkg;

	localparam int COORD_W       = 16;
	localparam int IDX_W         = 12;
	localparam int DIST_W        = 34;
	localparam int SLOTS         = 4;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int MAX_NODES_DEF = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

endpackage

`default_nettype wire

>>> design/nfps_node_if.sv
// ----------------------------------------------------------------------------
// nfps_node_if
// Valid/ready channel carrying one node position word.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfps_node_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [nfps_pkg::COORD_W-1:0] node_x;
	logic signed [nfps_pkg::COORD_W-1:0] node_y;
	logic signed [nfps_pkg::COORD_W-1:0] node_z;
	logic                                 last_node;

	modport source (output valid, node_x, node_y, node_z, last_node, input ready);
	modport sink   (input valid, node_x, node_y, node_z, last_node, output ready);

endinterface

`default_nettype wire

>>> design/nfps_near_if.sv
// ----------------------------------------------------------------------------
// nfps_near_if
// Valid/ready channel carrying the four nearest indices and distances.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfps_near_if;

	logic                          valid;
	logic                          ready;
	logic [nfps_pkg::IDX_W-1:0]   nearest_index_0;
	logic [nfps_pkg::IDX_W-1:0]   nearest_index_1;
	logic [nfps_pkg::IDX_W-1:0]   nearest_index_2;
	logic [nfps_pkg::IDX_W-1:0]   nearest_index_3;
	logic [nfps_pkg::DIST_W-1:0]  nearest_dist_0;
	logic [nfps_pkg::DIST_W-1:0]  nearest_dist_1;
	logic [nfps_pkg::DIST_W-1:0]  nearest_dist_2;
	logic [nfps_pkg::DIST_W-1:0]  nearest_dist_3;

	modport source (
		output valid, nearest_index_0, nearest_index_1, nearest_index_2, nearest_index_3,
		output nearest_dist_0, nearest_dist_1, nearest_dist_2, nearest_dist_3,
		input ready
	);
	modport sink (
		input valid, nearest_index_0, nearest_index_1, nearest_index_2, nearest_index_3,
		input nearest_dist_0, nearest_dist_1, nearest_dist_2, nearest_dist_3,
		output ready
	);

endinterface

`default_nettype wire

>>> design/nearest_four_point_select.sv
// ----------------------------------------------------------------------------
// nearest_four_point_select
// Keeps the four nearest nodes of a stream of 3D positions to a query point
// and emits their indices and squared distances on the word marked last.
// ----------------------------------------------------------------------------
// A last word passes stage 1, stage 2 and then the result register.
// Throughput: one node word per cycle; the three 16x16 squares and the
// four-slot compare-insert each sit in their own register stage.
// The input stalls only when a last word meets a full, unread result register.
// Reset (arst_n low): query point zero, pipeline and result empty, next node
// is treated as the first of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_four_point_select #(
	parameter int MAX_NODES = nfps_pkg::MAX_NODES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [nfps_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire [nfps_pkg::CFG_W-1:0]         cfg_data,
	nfps_node_if.sink                         node,
	nfps_near_if.source                       nearest
);

	localparam int IDX_MAX   = (1 << nfps_pkg::IDX_W) - 1;
	localparam int CNT_LIMIT = (MAX_NODES - 1 > IDX_MAX) ? IDX_MAX : (MAX_NODES - 1);
	localparam int SQ_W      = 2 * nfps_pkg::COORD_W;

	typedef logic [nfps_pkg::COORD_W-1:0] mag_t;
	typedef logic [nfps_pkg::DIST_W-1:0]  dist_t;
	typedef logic [nfps_pkg::IDX_W-1:0]   idx_t;

	// Magnitude of a - b; the difference of two 16-bit signed values fits
	// 17 bits signed, so its magnitude fits 16 bits unsigned.
	function automatic mag_t abs_diff(
		input logic signed [nfps_pkg::COORD_W-1:0] a,
		input logic signed [nfps_pkg::COORD_W-1:0] b
	);
		logic signed [nfps_pkg::COORD_W:0] d;
		logic        [nfps_pkg::COORD_W:0] m;
		d = {a[nfps_pkg::COORD_W-1], a} - {b[nfps_pkg::COORD_W-1], b};
		m = d[nfps_pkg::COORD_W] ? (~d + 1'b1) : d;
		return m[nfps_pkg::COORD_W-1:0];
	endfunction

	// ---------------------------------------------------------------- config
	logic signed [nfps_pkg::COORD_W-1:0] query_x_q, query_y_q, query_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
			query_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				nfps_pkg::REG_QUERY_X: query_x_q <= cfg_data;
				nfps_pkg::REG_QUERY_Y: query_y_q <= cfg_data;
				nfps_pkg::REG_QUERY_Z: query_z_q <= cfg_data;
				default: ;	// unknown index: drop the write
			endcase
		end
	end

	// ---------------------------------------------------------- flow control
	// A stage moves when the one ahead of it is empty or moving. Only a last
	// word needs the result register, so only it can hold stage 2.
	logic v_s1, v_s2;
	logic last_s1, last_s2;
	logic out_v_q;
	logic fire_s2, en_s2, en_s1;

	assign fire_s2    = v_s2 && !(last_s2 && out_v_q && !nearest.ready);
	assign en_s2      = !v_s2 || fire_s2;
	assign en_s1      = !v_s1 || en_s2;
	assign node.ready = en_s1;

	// --------------------------------------------------- stage 1: differences
	mag_t adx_s1, ady_s1, adz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= node.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			adx_s1  <= abs_diff(node.node_x, query_x_q);
			ady_s1  <= abs_diff(node.node_y, query_y_q);
			adz_s1  <= abs_diff(node.node_z, query_z_q);
			last_s1 <= node.last_node;
		end
	end

	// ---------------------------------------------- stage 2: squared distance
	logic [SQ_W-1:0] sqx_w, sqy_w, sqz_w;
	dist_t           dist_w, dist_s2;

	assign sqx_w  = adx_s1 * adx_s1;
	assign sqy_w  = ady_s1 * ady_s1;
	assign sqz_w  = adz_s1 * adz_s1;
	assign dist_w = dist_t'(sqx_w) + dist_t'(sqy_w) + dist_t'(sqz_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dist_s2 <= dist_w;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------- sorted list insertion
	dist_t best_dist_q [nfps_pkg::SLOTS];
	idx_t  best_idx_q  [nfps_pkg::SLOTS];
	idx_t  node_cnt_q;
	logic  first_q;

	dist_t best_dist_nx [nfps_pkg::SLOTS];
	idx_t  best_idx_nx  [nfps_pkg::SLOTS];
	logic  gt_w         [nfps_pkg::SLOTS];
	logic  insert_w;

	// Slots stay sorted, so the set of slots farther than the new distance
	// is a contiguous tail. Each tail slot takes its upper neighbor, and the
	// head of the tail takes the new node. Ties leave the earlier node ahead.
	assign insert_w = dist_s2 < best_dist_q[nfps_pkg::SLOTS-1];

	always_comb begin
		for (int k = 0; k < nfps_pkg::SLOTS; k++) begin
			gt_w[k] = best_dist_q[k] > dist_s2;
		end
		for (int k = 0; k < nfps_pkg::SLOTS; k++) begin
			best_dist_nx[k] = best_dist_q[k];
			best_idx_nx[k]  = best_idx_q[k];
			if (first_q) begin
				best_dist_nx[k] = dist_s2;
				best_idx_nx[k]  = node_cnt_q;
			end else if (insert_w && gt_w[k]) begin
				if (k > 0 && gt_w[(k > 0) ? k - 1 : 0]) begin
					best_dist_nx[k] = best_dist_q[(k > 0) ? k - 1 : 0];
					best_idx_nx[k]  = best_idx_q[(k > 0) ? k - 1 : 0];
				end else begin
					best_dist_nx[k] = dist_s2;
					best_idx_nx[k]  = node_cnt_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < nfps_pkg::SLOTS; k++) begin
				best_dist_q[k] <= '0;
				best_idx_q[k]  <= '0;
			end
			node_cnt_q <= '0;
			first_q    <= 1'b1;
		end else if (fire_s2) begin
			for (int k = 0; k < nfps_pkg::SLOTS; k++) begin
				best_dist_q[k] <= best_dist_nx[k];
				best_idx_q[k]  <= best_idx_nx[k];
			end
			if (last_s2) begin
				// close the query: restart indexing and refill on the next node
				node_cnt_q <= '0;
				first_q    <= 1'b1;
			end else begin
				first_q <= 1'b0;
				// saturate the index at the node bound
				if (node_cnt_q < idx_t'(CNT_LIMIT)) begin
					node_cnt_q <= node_cnt_q + 1'b1;
				end
			end
		end
	end

	// -------------------------------------------------------- result register
	dist_t out_dist_q [nfps_pkg::SLOTS];
	idx_t  out_idx_q  [nfps_pkg::SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire_s2 && last_s2) begin
			out_v_q <= 1'b1;
		end else if (nearest.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2 && last_s2) begin
			for (int k = 0; k < nfps_pkg::SLOTS; k++) begin
				out_dist_q[k] <= best_dist_nx[k];
				out_idx_q[k]  <= best_idx_nx[k];
			end
		end
	end

	assign nearest.valid           = out_v_q;
	assign nearest.nearest_index_0 = out_idx_q[0];
	assign nearest.nearest_index_1 = out_idx_q[1];
	assign nearest.nearest_index_2 = out_idx_q[2];
	assign nearest.nearest_index_3 = out_idx_q[3];
	assign nearest.nearest_dist_0  = out_dist_q[0];
	assign nearest.nearest_dist_1  = out_dist_q[1];
	assign nearest.nearest_dist_2  = out_dist_q[2];
	assign nearest.nearest_dist_3  = out_dist_q[3];

endmodule

`default_nettype wire

>>> tb/nfps_nearest_checker.sv
// ----------------------------------------------------------------------------
// nfps_nearest_checker
// Follows every node word into its own sorted list of the four nearest nodes
// and compares each result word, field by field, with the oldest query that
// has closed.
// ----------------------------------------------------------------------------
module nfps_nearest_checker #(
	parameter int MAX_NODES = nfps_pkg::MAX_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nfps_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [nfps_pkg::CFG_W-1:0]     cfg_data,
	nfps_node_if                           node,
	nfps_near_if                           nearest,
	output int                             errors,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import nfps_pkg::*;

	localparam int IDX_TOP   = (1 << IDX_W) - 1;
	localparam int COUNT_CAP = (MAX_NODES - 1 > IDX_TOP) ? IDX_TOP : MAX_NODES - 1;

	typedef struct packed {
		logic [SLOTS-1:0][IDX_W-1:0]  idx;
		logic [SLOTS-1:0][DIST_W-1:0] dists;
	} nearest_set_t;

	logic signed [COORD_W-1:0] query_x;
	logic signed [COORD_W-1:0] query_y;
	logic signed [COORD_W-1:0] query_z;
	nearest_set_t              kept;
	int                        node_count;
	bit                        first_node;
	nearest_set_t              pending_nearest [$];

	initial begin
		query_x     = '0;
		query_y     = '0;
		query_z     = '0;
		kept        = '0;
		node_count  = 0;
		first_node  = 1'b1;
		errors      = 0;
		outstanding = 0;
	end

	function automatic logic [DIST_W-1:0] squared_distance(
		input logic signed [COORD_W-1:0] nx, ny, nz
	);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'(nx) - longint'(query_x);
		dy = longint'(ny) - longint'(query_y);
		dz = longint'(nz) - longint'(query_z);
		return DIST_W'(dx * dx + dy * dy + dz * dz);
	endfunction

	// Fold one node into the kept list; close the query on a last word.
	task automatic fold_node(input logic signed [COORD_W-1:0] nx, ny, nz, input logic last);
		logic [DIST_W-1:0] d;
		int                pos;
		int                k;
		d = squared_distance(nx, ny, nz);
		if (first_node) begin
			for (k = 0; k < SLOTS; k++) begin
				kept.dists[k] = d;
				kept.idx[k]   = IDX_W'(node_count);
			end
			first_node = 1'b0;
		end else if (d < kept.dists[SLOTS-1]) begin
			// slide farther entries down; equal ones keep their place ahead
			pos = SLOTS - 1;
			while (pos > 0 && kept.dists[pos-1] > d) begin
				kept.dists[pos] = kept.dists[pos-1];
				kept.idx[pos]   = kept.idx[pos-1];
				pos--;
			end
			kept.dists[pos] = d;
			kept.idx[pos]   = IDX_W'(node_count);
		end
		if (node_count < COUNT_CAP)
			node_count++;
		if (last) begin
			pending_nearest.insert(pending_nearest.size(), kept);
			node_count = 0;
			first_node = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		nearest_set_t got;
		nearest_set_t want;
		int           k;
		if (arst_n) begin
			if (nearest.valid && nearest.ready) begin
				got.idx   = {nearest.nearest_index_3, nearest.nearest_index_2,
				             nearest.nearest_index_1, nearest.nearest_index_0};
				got.dists = {nearest.nearest_dist_3, nearest.nearest_dist_2,
				             nearest.nearest_dist_1, nearest.nearest_dist_0};
				if (pending_nearest.size() == 0) begin
					$error("nearest word with no closed query waiting");
					errors++;
				end else begin
					want = pending_nearest.pop_front();
					for (k = 0; k < SLOTS; k++) begin
						if (got.idx[k] !== want.idx[k]) begin
							$error("nearest_index_%0d: expected %0d, got %0d",
							       k, want.idx[k], got.idx[k]);
							errors++;
						end
						if (got.dists[k] !== want.dists[k]) begin
							$error("nearest_dist_%0d: expected %0d, got %0d",
							       k, want.dists[k], got.dists[k]);
							errors++;
						end
					end
				end
			end
			if (node.valid && node.ready)
				fold_node(node.node_x, node.node_y, node.node_z, node.last_node);
			// a write counts from the next node on
			if (cfg_we) begin
				case (cfg_idx)
					REG_QUERY_X: query_x = cfg_data;
					REG_QUERY_Y: query_y = cfg_data;
					REG_QUERY_Z: query_z = cfg_data;
					default: ;
				endcase
			end
			outstanding <= pending_nearest.size();
		end
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives node words and query writes into nearest_four_point_select, throttles
// the result side, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nfps_pkg::*;

	localparam int     CLK_PERIOD     = 12;
	localparam int     RESET_CYCLES   = 8;
	localparam int     NODE_LIMIT     = MAX_NODES_DEF;
	// a last word passes stage 1, stage 2 and the result register; leave margin
	localparam int     SETTLE_CYCLES  = 8;
	localparam int     PHASE_WORDS    = 155;
	localparam int     RX_HOLD_CYCLES = 400;
	localparam longint RUN_LIMIT_NS   = 2_000_000;

	localparam logic [CFG_IDX_W-1:0]      REG_UNUSED = 2'd3;
	localparam logic signed [COORD_W-1:0] COORD_MIN  = 16'sh8000;
	localparam logic signed [COORD_W-1:0] COORD_MAX  = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] COORD_ZERO = 16'sh0000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_W-1:0]      cfg_data;

	int                    tx_idle_pct  = 0;
	int                    rx_idle_pct  = 0;
	bit                    rx_hold_go   = 1'b0;
	int                    words_sent   = 0;
	int                    errors;
	int                    outstanding;

	// our copy of the query point, used to aim nodes near it
	logic signed [COORD_W-1:0] cur_x = '0;
	logic signed [COORD_W-1:0] cur_y = '0;
	logic signed [COORD_W-1:0] cur_z = '0;

	nfps_node_if node_ch ();
	nfps_near_if near_ch ();

	nearest_four_point_select #(
		.MAX_NODES(NODE_LIMIT)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.node    (node_ch),
		.nearest (near_ch)
	);

	nfps_nearest_checker #(
		.MAX_NODES(NODE_LIMIT)
	) u_nearest_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.node       (node_ch),
		.nearest    (near_ch),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case a handshake never completes or a result never shows.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

	// Result side: random ready at the current idle rate. Once asked, hold
	// ready low for a long stretch so the result register fills and the node
	// input has to stall behind it.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		near_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_go && !hold_done) begin
				hold_left = RX_HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				near_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				near_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Offer one node word; idle first at the current rate, then hold it until
	// the block takes it. Valid stays high on return so the next word can
	// follow without a bubble.
	task automatic send_node(input logic signed [COORD_W-1:0] x, y, z, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			node_ch.valid <= 1'b0;
			@(posedge clk);
		end
		node_ch.valid     <= 1'b1;
		node_ch.node_x    <= x;
		node_ch.node_y    <= y;
		node_ch.node_z    <= z;
		node_ch.last_node <= last;
		do @(posedge clk); while (!node_ch.ready);
		words_sent++;
	endtask

	// Drop valid, wait for every closed query to report, then let the
	// pipeline empty out before anyone touches the registers.
	task automatic settle();
		node_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller drops it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_query(input logic signed [COORD_W-1:0] x, y, z);
		write_reg(REG_QUERY_X, x);
		write_reg(REG_QUERY_Y, y);
		write_reg(REG_QUERY_Z, z);
		cfg_we <= 1'b0;
		cur_x = x;
		cur_y = y;
		cur_z = z;
	endtask

	// Mix of anywhere, near the query, right on top of it (to make ties)
	// and the two ends of the range.
	function automatic logic signed [COORD_W-1:0] pick_coord(
		input logic signed [COORD_W-1:0] center
	);
		case ($urandom_range(9))
			0, 1, 2, 3: return COORD_W'($urandom);
			4, 5:       return center + COORD_W'($urandom_range(128)) - COORD_W'(64);
			6, 7:       return center + COORD_W'($urandom_range(4)) - COORD_W'(2);
			8:          return COORD_MIN;
			default:    return COORD_MAX;
		endcase
	endfunction

	task automatic send_random_node(input logic last);
		send_node(pick_coord(cur_x), pick_coord(cur_y), pick_coord(cur_z), last);
	endtask

	initial begin
		int n;
		int i;
		int phase;
		int phase_end;

		// every input known from time zero; reset held low at the start
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_idx           <= '0;
		cfg_data          <= '0;
		node_ch.valid     <= 1'b0;
		node_ch.node_x    <= '0;
		node_ch.node_y    <= '0;
		node_ch.node_z    <= '0;
		node_ch.last_node <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---

		// Query still at its reset origin; a one-node query copies that node
		// into all four slots.
		send_node(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		settle();

		// Opposite corners: the largest distance the block can see.
		set_query(COORD_MAX, COORD_MAX, COORD_MAX);
		send_node(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		settle();

		// Three nodes only: the untouched slot keeps a copy of the first.
		set_query(COORD_MIN, COORD_MAX, COORD_ZERO);
		send_node(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
		send_node(COORD_MIN, COORD_MAX, COORD_ZERO, 1'b0);
		send_node(COORD_ZERO, COORD_ZERO, COORD_MIN, 1'b1);
		settle();

		// Ties at distance one: earlier nodes stay ahead and all four equal
		// ones get in; the exact hit at the end goes to the front.
		set_query(COORD_ZERO, COORD_ZERO, COORD_ZERO);
		send_node(16'sd3, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd1, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd0, 16'sd1, 16'sd0, 1'b0);
		send_node(16'sd0, 16'sd0, -16'sd1, 1'b0);
		send_node(-16'sd1, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd0, 16'sd0, 16'sd0, 1'b1);
		settle();

		// Each node closer than all before: every insert shifts the whole list.
		send_node(16'sd50, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd40, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd30, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd20, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd10, 16'sd0, 16'sd0, 1'b1);
		settle();

		// Move the query in the middle of a query: kept distances stand,
		// later nodes use the new point.
		send_node(16'sd100, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd200, 16'sd0, 16'sd0, 1'b0);
		settle();
		write_reg(REG_QUERY_X, 16'sd200);
		cfg_we <= 1'b0;
		cur_x = 16'sd200;
		send_node(16'sd200, 16'sd0, 16'sd0, 1'b0);
		send_node(16'sd0, 16'sd0, 16'sd0, 1'b1);
		settle();

		// A write to the unused index must leave the query alone.
		write_reg(REG_UNUSED, 16'h7FFF);
		cfg_we <= 1'b0;
		send_node(16'sd5, -16'sd5, 16'sd5, 1'b1);

		// --- random queries, three idling profiles ---
		// Phase 0: sender idles 32%, receiver 48%. Phase 1: the reverse.
		// Phase 2: no idling, but the receiver stalls hard at the start.
		for (phase = 0; phase < 3; phase++) begin
			settle();
			case (phase)
				0: begin
					tx_idle_pct = 32;
					rx_idle_pct = 48;
					set_query(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
				end
				1: begin
					tx_idle_pct = 48;
					rx_idle_pct = 32;
					set_query(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					set_query(COORD_MIN, COORD_MAX, COORD_MIN);
					rx_hold_go = 1'b1;
				end
			endcase
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				// mostly short queries, now and then a longer one
				n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
				for (i = 0; i < n; i++)
					send_random_node(i == n - 1);
			end
		end

		settle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
